// ===== hdl/dfpa_pkg.sv =====
package dfpa_pkg;

  // request codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;
  localparam logic [2:0] OP_I2D = 3'd5;
  localparam logic [2:0] OP_D2I = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [63:0] SCALE   = 64'd100000;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = 64;

  // what travels alongside the arithmetic
  typedef struct packed {
    logic [2:0]  op;
    logic        neg;
    logic        lt;
    logic        eq;
    logic        dz;
    logic        sum_ovf;
    logic [63:0] sum;
  } meta_t;

  // classified request held in the queue
  typedef struct packed {
    meta_t       meta;
    logic [63:0] mul_x;
    logic [63:0] mul_y;
    logic [63:0] divisor;
  } req_t;

endpackage

// ===== hdl/dfpa_front.sv =====
module dfpa_front (
  input  logic [2:0]      req_type,
  input  logic [63:0]     operand_a,
  input  logic [63:0]     operand_b,
  output dfpa_pkg::req_t  req
);
  import dfpa_pkg::*;

  logic [63:0] mag_a;
  logic [63:0] mag_b;
  logic [63:0] b_x;
  logic [63:0] sum;
  logic        is_sub;

  // magnitudes
  assign mag_a = operand_a[63] ? (~operand_a + 64'd1) : operand_a;
  assign mag_b = operand_b[63] ? (~operand_b + 64'd1) : operand_b;

  // add or subtract with saturation check
  assign is_sub = (req_type == OP_SUB);
  assign b_x    = is_sub ? ~operand_b : operand_b;
  assign sum    = operand_a + b_x + {63'd0, is_sub};

  always_comb begin
    req.meta.op      = req_type;
    req.meta.lt      = $signed(operand_a) < $signed(operand_b);
    req.meta.eq      = (operand_a == operand_b);
    req.meta.dz      = (operand_b == 64'd0);
    req.meta.sum_ovf = (operand_a[63] == b_x[63]) && (sum[63] != operand_a[63]);
    req.meta.sum     = req.meta.sum_ovf ? (operand_a[63] ? NEG_MAX : POS_MAX) : sum;
    req.meta.neg     = operand_a[63];
    req.mul_x        = mag_a;
    req.mul_y        = 64'd0;
    req.divisor      = 64'd1;
    unique case (req_type)
      OP_MUL: begin
        req.meta.neg = operand_a[63] ^ operand_b[63];
        req.mul_y    = mag_b;
        req.divisor  = SCALE;
      end
      OP_DIV: begin
        req.meta.neg = operand_a[63] ^ operand_b[63];
        req.mul_y    = SCALE;
        req.divisor  = req.meta.dz ? 64'd1 : mag_b;
      end
      OP_I2D: begin
        req.mul_y    = SCALE;
      end
      OP_D2I: begin
        req.mul_y    = 64'd1;
        req.divisor  = SCALE;
      end
      default: begin
        req.mul_y    = 64'd0;
      end
    endcase
  end

endmodule

// ===== hdl/dfpa_queue.sv =====
module dfpa_queue #(
  parameter int DEPTH = dfpa_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dfpa_pkg::req_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output dfpa_pkg::req_t  head
);
  import dfpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             entries [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/dfpa_back.sv =====
module dfpa_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  dfpa_pkg::req_t  in_req,
  output logic            take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     result,
  output logic [1:0]      status,
  output logic            less_than,
  output logic            equal
);
  import dfpa_pkg::*;

  logic adv;

  // partial products
  logic        s1_valid;
  meta_t       s1_meta;
  logic [63:0] s1_p00, s1_p01, s1_p10, s1_p11;
  logic [63:0] s1_div;

  // full product
  logic         s2_valid;
  meta_t        s2_meta;
  logic [127:0] s2_prod;
  logic [63:0]  s2_div;

  // restoring divider stages
  logic        dv_valid [0:DIV_STEPS];
  meta_t       dv_meta  [0:DIV_STEPS];
  logic [63:0] dv_rem   [0:DIV_STEPS];
  logic [63:0] dv_quo   [0:DIV_STEPS];
  logic [63:0] dv_div   [0:DIV_STEPS];
  logic        dv_ovf   [0:DIV_STEPS];

  logic [63:0] q;
  logic        fin_ovf;
  meta_t       fin_meta;
  logic [63:0] res_next;
  logic [1:0]  status_next;
  logic        sat;

  // whole pipeline moves together unless the result is held
  assign adv  = !out_valid || !out_stall;
  assign take = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta <= in_req.meta;
      s1_div  <= in_req.divisor;
      s1_p00  <= {32'd0, in_req.mul_x[31:0]}  * {32'd0, in_req.mul_y[31:0]};
      s1_p01  <= {32'd0, in_req.mul_x[31:0]}  * {32'd0, in_req.mul_y[63:32]};
      s1_p10  <= {32'd0, in_req.mul_x[63:32]} * {32'd0, in_req.mul_y[31:0]};
      s1_p11  <= {32'd0, in_req.mul_x[63:32]} * {32'd0, in_req.mul_y[63:32]};
      s2_meta <= s1_meta;
      s2_div  <= s1_div;
      s2_prod <= {64'd0, s1_p00} + {32'd0, s1_p01, 32'd0}
               + {32'd0, s1_p10, 32'd0} + {s1_p11, 64'd0};
    end
  end

  // first divider stage: a high half at or above the divisor means overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_meta[0] <= s2_meta;
      dv_div[0]  <= s2_div;
      dv_rem[0]  <= s2_prod[127:64];
      dv_quo[0]  <= s2_prod[63:0];
      dv_ovf[0]  <= (s2_prod[127:64] >= s2_div);
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [63:0] trial;
    logic        ge;

    assign trial = {dv_rem[k-1][62:0], dv_quo[k-1][63]};
    assign ge    = (trial >= dv_div[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (adv) begin
        dv_valid[k] <= dv_valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_meta[k] <= dv_meta[k-1];
        dv_div[k]  <= dv_div[k-1];
        dv_ovf[k]  <= dv_ovf[k-1];
        dv_rem[k]  <= ge ? (trial - dv_div[k-1]) : trial;
        dv_quo[k]  <= {dv_quo[k-1][62:0], ge};
      end
    end
  end

  // sign, saturation and status
  assign q        = dv_quo[DIV_STEPS];
  assign fin_ovf  = dv_ovf[DIV_STEPS];
  assign fin_meta = dv_meta[DIV_STEPS];

  always_comb begin
    sat         = fin_meta.neg ? (fin_ovf || (q[63] && (q[62:0] != 63'd0)))
                               : (fin_ovf || q[63]);
    res_next    = 64'd0;
    status_next = ST_OK;
    unique case (fin_meta.op)
      OP_ADD, OP_SUB: begin
        res_next    = fin_meta.sum;
        status_next = fin_meta.sum_ovf ? ST_OVF : ST_OK;
      end
      OP_MUL, OP_DIV, OP_I2D: begin
        if (fin_meta.op == OP_DIV && fin_meta.dz) begin
          res_next    = 64'd0;
          status_next = ST_DZ;
        end else if (sat) begin
          res_next    = fin_meta.neg ? NEG_MAX : POS_MAX;
          status_next = ST_OVF;
        end else begin
          res_next    = fin_meta.neg ? (~q + 64'd1) : q;
        end
      end
      OP_D2I: begin
        res_next    = fin_meta.neg ? (~q + 64'd1) : q;
      end
      default: begin
        res_next    = 64'd0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result    <= res_next;
      status    <= status_next;
      less_than <= fin_meta.lt;
      equal     <= fin_meta.eq;
    end
  end

endmodule

// ===== hdl/decimal_fixed_point_alu_unit.sv =====
// decimal fixed-point alu, scale 100000, 64-bit signed operands
// path: queue, two-stage multiplier, divider stages, result register
// throughput: one request per cycle while out_stall is low and the queue has
// room; pipelined 32x32 partial-product multiplier, 64-step restoring divider
// reset: synchronous active-high rst empties the queue and clears all valids
module decimal_fixed_point_alu_unit #(
  parameter int QUEUE_DEPTH = dfpa_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result,
  output logic [1:0]  status,
  output logic        less_than,
  output logic        equal
);
  import dfpa_pkg::*;

  req_t front_req;
  req_t head_req;
  logic q_full;
  logic q_not_empty;
  logic back_take;

  // classify the request
  dfpa_front u_front (
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .req       (front_req)
  );

  assign in_stall = q_full;

  // decoupling queue
  dfpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (front_req),
    .full      (q_full),
    .pop       (back_take),
    .not_empty (q_not_empty),
    .head      (head_req)
  );

  // arithmetic pipeline
  dfpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_not_empty),
    .in_req    (head_req),
    .take      (back_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .status    (status),
    .less_than (less_than),
    .equal     (equal)
  );

endmodule
